### hdl/segy_pkg.sv
// ----------------------------------------------------------------------------
// segy_pkg
// shared types and constants for the trace sample decoder
// ----------------------------------------------------------------------------
package segy_pkg;

  localparam int unsigned TRACE_HEADER_BYTES = 240;
  localparam int unsigned POS_W = 18;
  localparam int unsigned LEN_W = 15;
  localparam int unsigned FMT_W = 3;
  localparam int unsigned FTN_W = 31;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] REG_TRACE_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FORMAT_CODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_TRACE = 2'd2;

  localparam logic [FMT_W-1:0] FMT_INT16 = 3'd3;
  localparam logic [FMT_W-1:0] FMT_IEEE = 3'd5;

  typedef enum logic [1:0] {
    KIND_IBM = 2'd0,
    KIND_INT16 = 2'd1,
    KIND_IEEE = 2'd2
  } kind_t;

  // one assembled sample handed from front to back
  typedef struct packed {
    kind_t       kind;
    logic [31:0] word;
    logic [14:0] sample_index;
    logic [31:0] trace_number;
    logic        last_of_trace;
  } raw_sample_t;

  // index of the highest set bit of a 24-bit value (0 for zero)
  function automatic logic [4:0] top_bit24(input logic [23:0] v);
    logic [4:0] p;
    p = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (v[i]) p = 5'(i);
    end
    return p;
  endfunction

endpackage

### hdl/segy_front.sv
// ----------------------------------------------------------------------------
// segy_front
// skips trace headers, assembles big-endian samples and numbers them
// ----------------------------------------------------------------------------
module segy_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [segy_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [segy_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  in_byte,
  output logic                        push,
  output segy_pkg::raw_sample_t       push_data,
  input  logic                        q_full
);
  import segy_pkg::*;

  logic [LEN_W-1:0] trace_length;
  logic [FMT_W-1:0] format_code;
  logic [POS_W-1:0] byte_position;
  logic [23:0]      partial_sample;
  logic [LEN_W-1:0] sample_counter;
  logic [31:0]      trace_counter;

  logic             take, in_header, is16, complete, last;
  logic [POS_W-1:0] off;
  logic [15:0]      cnt_plus;

  assign in_ready  = !q_full;
  assign take      = in_valid && in_ready;
  assign is16      = (format_code == FMT_INT16);
  assign in_header = (byte_position < POS_W'(TRACE_HEADER_BYTES));
  assign off       = byte_position - POS_W'(TRACE_HEADER_BYTES);
  assign complete  = !in_header && (is16 ? off[0] : (off[1:0] == 2'b11));
  assign cnt_plus  = {1'b0, sample_counter} + 16'd1;
  assign last      = cnt_plus >= {1'b0, trace_length};
  assign push      = take && complete;

  always_comb begin
    push_data.kind = is16 ? KIND_INT16 : ((format_code == FMT_IEEE) ? KIND_IEEE : KIND_IBM);
    push_data.word = is16 ? {16'd0, partial_sample[7:0], in_byte}
                          : {partial_sample, in_byte};
    push_data.sample_index  = sample_counter;
    push_data.trace_number  = trace_counter;
    push_data.last_of_trace = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trace_length   <= LEN_W'(1);
      format_code    <= FMT_W'(1);
      byte_position  <= '0;
      partial_sample <= '0;
      sample_counter <= '0;
      trace_counter  <= '0;
    end else begin
      if (take) begin
        if (in_header) begin
          byte_position <= byte_position + POS_W'(1);
        end else if (!complete) begin
          partial_sample <= {partial_sample[15:0], in_byte};
          byte_position  <= byte_position + POS_W'(1);
        end else begin
          partial_sample <= '0;
          if (last) begin
            byte_position  <= '0;
            sample_counter <= '0;
            trace_counter  <= trace_counter + 32'd1;
          end else begin
            byte_position  <= byte_position + POS_W'(1);
            sample_counter <= cnt_plus[LEN_W-1:0];
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_TRACE_LENGTH: trace_length <= cfg_data[LEN_W-1:0];
          REG_FORMAT_CODE:  format_code <= cfg_data[FMT_W-1:0];
          REG_FIRST_TRACE:  trace_counter <= {1'b0, cfg_data[FTN_W-1:0]};
          default: ;
        endcase
      end
    end
  end

endmodule

### hdl/segy_queue.sv
// ----------------------------------------------------------------------------
// segy_queue
// four-entry fifo between front and back
// ----------------------------------------------------------------------------
module segy_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  segy_pkg::raw_sample_t push_data,
  output logic                  full,
  input  logic                  pop,
  output logic                  not_empty,
  output segy_pkg::raw_sample_t head
);
  import segy_pkg::*;

  raw_sample_t mem [4];
  logic [1:0]  wr_ptr, rd_ptr;
  logic [2:0]  count;

  assign full      = (count == 3'd4);
  assign not_empty = (count != 3'd0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count + 3'(push) - 3'(pop);
    end
  end

endmodule

### hdl/segy_back.sv
// ----------------------------------------------------------------------------
// segy_back
// converts samples to ieee single in two stages with an output register
// ----------------------------------------------------------------------------
module segy_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  segy_pkg::raw_sample_t q_head,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [31:0]           out_bits,
  output logic [14:0]           out_index,
  output logic [31:0]           out_trace,
  output logic                  out_last
);
  import segy_pkg::*;

  // stage one: classify and find leading bit
  logic        s1_valid;
  raw_sample_t s1;
  logic [4:0]  s1_p;
  logic [23:0] s1_f;
  logic        s1_sign;

  logic        adv1, adv2;
  logic [23:0] f_in;
  logic        sign_in;

  always_comb begin
    if (q_head.kind == KIND_INT16) begin
      sign_in = q_head.word[15];
      f_in = q_head.word[15] ? {8'd0, 16'(17'h10000 - {1'b0, q_head.word[15:0]})}
                             : {8'd0, q_head.word[15:0]};
      if (q_head.word[15:0] == 16'h8000) f_in = 24'h008000;
    end else begin
      sign_in = q_head.word[31];
      f_in = q_head.word[23:0];
    end
  end

  assign adv2  = !out_valid || out_ready;
  assign adv1  = !s1_valid || adv2;
  assign q_pop = q_valid && adv1;

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (adv1) s1_valid <= q_valid;
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1      <= q_head;
      s1_f    <= f_in;
      s1_sign <= sign_in;
      s1_p    <= top_bit24(f_in);
    end
  end

  // stage two: build the result
  logic [31:0] res;
  logic [6:0]  e;
  logic signed [10:0] biased, sh;
  logic [23:0] q, r, half, mask;
  logic [47:0] norm;
  logic [4:0]  shu;

  always_comb begin
    e      = s1.word[30:24];
    biased = 11'(s1_p) + 11'($signed({4'd0, e, 2'b00})) - 11'sd153;
    sh     = 11'sd131 - 11'($signed({2'd0, e, 2'b00}));
    norm   = {24'd0, s1_f} << (5'd23 - s1_p);
    shu    = sh[4:0];
    mask   = (24'd1 << shu) - 24'd1;
    q      = s1_f >> shu;
    r      = s1_f & mask;
    half   = 24'd1 << (shu - 5'd1);
    res    = {s1_sign, 31'd0};
    case (s1.kind)
      KIND_IEEE: res = s1.word;
      KIND_INT16: begin
        if (s1_f != 24'd0)
          res = {s1_sign, 8'(8'd127 + {3'd0, s1_p}), norm[22:0]};
      end
      default: begin
        if (s1_f == 24'd0) begin
          res = {s1_sign, 31'd0};
        end else if (biased >= 11'sd255) begin
          res = {s1_sign, 31'h7f800000};
        end else if (biased >= 11'sd1) begin
          res = {s1_sign, biased[7:0], norm[22:0]};
        end else if (sh <= 11'sd0) begin
          res = {s1_sign, 31'({7'd0, s1_f} << 5'(-sh))};
        end else if (sh > 11'sd24) begin
          res = {s1_sign, 31'd0};
        end else begin
          if (r > half || (r == half && q[0])) q = q + 24'd1;
          res = {s1_sign, 7'd0, q};
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv2) out_valid <= s1_valid;
  end

  always_ff @(posedge clk) begin
    if (adv2 && s1_valid) begin
      out_bits  <= res;
      out_index <= s1.sample_index;
      out_trace <= s1.trace_number;
      out_last  <= s1.last_of_trace;
    end
  end

endmodule

### hdl/segy_trace_sample_decoder_unit.sv
// path: the last byte of a sample is written into the queue, then registered in stage one and the output register
// throughput: one byte per cycle while the queue is not full; a four-entry queue decouples input from conversion
// the conversion pipeline holds when m_tvalid is high and m_tready is low and the queue absorbs the rest
// synchronous active-high reset clears counters, queue and pipeline and
// restores trace_length 1, format 1, trace number 0
// ----------------------------------------------------------------------------
// segy_trace_sample_decoder_unit
// seg-y trace byte stream to ieee single samples
// ----------------------------------------------------------------------------
module segy_trace_sample_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // sample_bits, sample_index, trace_number, zero pad
  output logic        m_tlast    // last_of_trace
);
  import segy_pkg::*;

  logic        push, full, pop, ne;
  raw_sample_t pd, head;
  logic [31:0] bits, trace;
  logic [14:0] idx;

  segy_front u_front (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid(s_tvalid), .in_ready(s_tready), .in_byte(s_tdata),
    .push, .push_data(pd), .q_full(full)
  );

  segy_queue u_queue (
    .clk, .rst, .push, .push_data(pd), .full, .pop, .not_empty(ne), .head
  );

  segy_back u_back (
    .clk, .rst, .q_valid(ne), .q_head(head), .q_pop(pop),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .out_bits(bits), .out_index(idx), .out_trace(trace), .out_last(m_tlast)
  );

  assign m_tdata = {1'b0, trace, idx, bits};

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    full |-> !push) else $error("push into full queue");
  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("output dropped");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> ne) else $error("pop from empty queue");
`endif

endmodule
